[hdl/mlpq_pkg.sv]
`default_nettype none

package mlpq_pkg;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_REMOVED  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_BADPRIO  = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic capture;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic needs_read;
	} dp_stat_t;

endpackage

`default_nettype wire

[hdl/mlpq_ram.sv]
`default_nettype none

module mlpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 50
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hdl/mlpq_dp.sv]
`default_nettype none

module mlpq_dp #(
	parameter int LEVELS      = 5,
	parameter int LEVEL_DEPTH = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mlpq_pkg::dp_cmd_t  cmd,
	output mlpq_pkg::dp_stat_t      stat,
	input  wire logic               command,
	input  wire logic signed [31:0] value,
	input  wire logic        [2:0]  priority_req,
	output logic                    done,
	output logic             [2:0]  status,
	output logic signed      [31:0] removed_value,
	output logic             [2:0]  removed_priority
);

	localparam int LW = $clog2(LEVELS);
	localparam int HW = $clog2(LEVEL_DEPTH);
	localparam int CW = $clog2(LEVEL_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int AW = $clog2(LEVELS * LEVEL_DEPTH);

	logic               cmd_q;
	logic signed [31:0] value_q;
	logic [2:0]         prio_q;

	logic [HW-1:0] head_q  [LEVELS];
	logic [CW-1:0] count_q [LEVELS];

	logic          done_q;
	logic [2:0]    status_q;
	logic [31:0]   rval_q;
	logic [2:0]    rprio_q;

	logic          prio_ok;
	logic [LW-1:0] ins_lvl;
	logic          ins_full;
	logic [SW-1:0] ins_sum;
	logic [HW-1:0] ins_pos;
	logic          found;
	logic [LW-1:0] rem_lvl;
	logic [HW-1:0] rem_head;
	logic [HW-1:0] rem_head_nx;
	logic [2:0]    rem_prio;
	logic [2:0]    status_nx;
	logic          do_write;
	logic          do_pop;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;

	// insert side: level, full check, tail slot
	always_comb begin
		prio_ok  = (prio_q != 3'd0) && (32'(prio_q) <= LEVELS);
		ins_lvl  = prio_ok ? LW'(32'(prio_q) - 32'd1) : '0;
		ins_full = 32'(count_q[ins_lvl]) >= LEVEL_DEPTH;
		ins_sum  = SW'(head_q[ins_lvl]) + SW'(count_q[ins_lvl]);
		// head + count stays below twice the depth
		if (32'(ins_sum) >= LEVEL_DEPTH) begin
			ins_pos = HW'(ins_sum - SW'(LEVEL_DEPTH));
		end else begin
			ins_pos = HW'(ins_sum);
		end
	end

	// remove side: highest non-empty level wins
	always_comb begin
		found   = 1'b0;
		rem_lvl = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (count_q[i] != '0) begin
				found   = 1'b1;
				rem_lvl = LW'(i);
			end
		end
		rem_head = head_q[rem_lvl];
		if (32'(rem_head) == LEVEL_DEPTH - 1) begin
			rem_head_nx = '0;
		end else begin
			rem_head_nx = rem_head + HW'(1);
		end
		rem_prio = 3'(32'(rem_lvl) + 32'd1);
	end

	always_comb begin
		if (cmd_q == mlpq_pkg::CMD_INSERT) begin
			if (!prio_ok) begin
				status_nx = mlpq_pkg::ST_BADPRIO;
			end else if (ins_full) begin
				status_nx = mlpq_pkg::ST_FULL;
			end else begin
				status_nx = mlpq_pkg::ST_INSERTED;
			end
		end else begin
			status_nx = found ? mlpq_pkg::ST_REMOVED : mlpq_pkg::ST_EMPTY;
		end
	end

	assign stat.needs_read = (cmd_q == mlpq_pkg::CMD_REMOVE) && found;
	assign do_write = cmd.exec && (cmd_q == mlpq_pkg::CMD_INSERT) && prio_ok && !ins_full;
	assign do_pop   = cmd.exec && stat.needs_read;
	assign waddr    = AW'(32'(ins_lvl) * LEVEL_DEPTH + 32'(ins_pos));
	assign raddr    = AW'(32'(rem_lvl) * LEVEL_DEPTH + 32'(rem_head));

	mlpq_ram #(
		.WIDTH(32),
		.DEPTH(LEVELS * LEVEL_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (do_write),
		.waddr(waddr),
		.wdata(value_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (do_write) begin
				count_q[ins_lvl] <= count_q[ins_lvl] + CW'(1);
			end
			if (do_pop) begin
				count_q[rem_lvl] <= count_q[rem_lvl] - CW'(1);
				head_q[rem_lvl]  <= rem_head_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= command;
			value_q <= value;
			prio_q  <= priority_req;
		end
		if (cmd.exec) begin
			status_q <= status_nx;
			rval_q   <= '0;
			rprio_q  <= stat.needs_read ? rem_prio : 3'd0;
		end
		if (cmd.capture) begin
			rval_q <= rdata;
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign removed_value    = signed'(rval_q);
	assign removed_priority = rprio_q;

endmodule

`default_nettype wire

[hdl/mlpq_ctrl.sv]
`default_nettype none

module mlpq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output mlpq_pkg::dp_cmd_t       cmd,
	input  wire mlpq_pkg::dp_stat_t stat
);

	mlpq_pkg::state_t state_q;
	mlpq_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlpq_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		busy     = 1'b1;
		unique case (state_q)
			mlpq_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_nx = mlpq_pkg::S_EXEC;
				end
			end
			mlpq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				// a successful remove goes to S_WAIT for the store read
				if (stat.needs_read) begin
					state_nx = mlpq_pkg::S_WAIT;
				end else begin
					cmd.finish = 1'b1;
					state_nx   = mlpq_pkg::S_IDLE;
				end
			end
			mlpq_pkg::S_WAIT: begin
				cmd.capture = 1'b1;
				cmd.finish  = 1'b1;
				state_nx    = mlpq_pkg::S_IDLE;
			end
			default: begin
				state_nx = mlpq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hdl/multi_level_priority_queue.sv]
// order: insert, rejected insert and empty remove pass from accept through S_EXEC to the
// registered done; a successful remove also passes through S_WAIT for the store read
// a new command is taken only back in S_IDLE; a successful remove is held up by the
// registered read port of the shared slot store; the receiver cannot stall, done is one cycle
// reset: all levels empty, heads at zero, done low; store contents are not cleared
`default_nettype none

module multi_level_priority_queue #(
	parameter int LEVELS      = 5,
	parameter int LEVEL_DEPTH = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               command,
	input  wire logic signed [31:0] value,
	input  wire logic        [2:0]  priority_req,
	output logic                    done,
	output logic             [2:0]  status,
	output logic signed      [31:0] removed_value,
	output logic             [2:0]  removed_priority
);

	mlpq_pkg::dp_cmd_t  cmd;
	mlpq_pkg::dp_stat_t stat;

	mlpq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.stat  (stat)
	);

	mlpq_dp #(
		.LEVELS     (LEVELS),
		.LEVEL_DEPTH(LEVEL_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.command         (command),
		.value           (value),
		.priority_req    (priority_req),
		.done            (done),
		.status          (status),
		.removed_value   (removed_value),
		.removed_priority(removed_priority)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not make the block busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a command in flight");

	a_removed_prio: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == mlpq_pkg::ST_REMOVED |-> removed_priority != 3'd0)
		else $error("removed word carries no priority");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != mlpq_pkg::ST_REMOVED |-> removed_value == 32'sd0
			&& removed_priority == 3'd0)
		else $error("non-remove result word has nonzero fields");

endmodule

`default_nettype wire

[tb/multi_level_priority_queue_tb.sv]
`default_nettype none

module multi_level_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEVELS      = 5;
	localparam int LEVEL_DEPTH = 10;

	typedef struct {
		bit                 drain;
		logic               command;
		logic signed [31:0] value;
		logic        [2:0]  prio;
		int unsigned        gap;
	} queue_cmd_t;

	typedef struct {
		logic        [2:0]  status;
		logic signed [31:0] value;
		logic        [2:0]  prio;
	} queue_reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               command = mlpq_pkg::CMD_INSERT;
	logic signed [31:0] value = '0;
	logic        [2:0]  priority_req = '0;
	wire logic          busy;
	wire logic          done;
	wire logic   [2:0]  status;
	wire logic   [31:0] removed_value;
	wire logic   [2:0]  removed_priority;

	queue_cmd_t   cmd_backlog[$];
	queue_reply_t expected_replies[$];

	// shadow of the per-level fifos
	logic [31:0] shadow_words[LEVELS][LEVEL_DEPTH];
	int unsigned shadow_head[LEVELS];
	int unsigned shadow_count[LEVELS];

	logic        took = 1'b0;
	logic        all_sent = 1'b0;
	int unsigned gap_left = 0;
	int unsigned err_count = 0;
	int unsigned n_ins = 0, n_rem = 0, n_full = 0, n_empty = 0, n_bad = 0;

	multi_level_priority_queue #(
		.LEVELS(LEVELS),
		.LEVEL_DEPTH(LEVEL_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.value(value),
		.priority_req(priority_req),
		.done(done),
		.status(status),
		.removed_value(removed_value),
		.removed_priority(removed_priority)
	);

	always #5 clk = ~clk;

	function automatic queue_reply_t predict_queue_op(queue_cmd_t c);
		queue_reply_t r;
		int unsigned lvl;
		r.status = mlpq_pkg::ST_EMPTY;
		r.value = '0;
		r.prio = '0;
		if (c.command == mlpq_pkg::CMD_INSERT) begin
			if (c.prio < 1 || c.prio > LEVELS) begin
				r.status = mlpq_pkg::ST_BADPRIO;
			end else begin
				lvl = c.prio - 1;
				if (shadow_count[lvl] >= LEVEL_DEPTH) begin
					r.status = mlpq_pkg::ST_FULL;
				end else begin
					shadow_words[lvl][(shadow_head[lvl] + shadow_count[lvl]) % LEVEL_DEPTH] = c.value;
					shadow_count[lvl]++;
					r.status = mlpq_pkg::ST_INSERTED;
				end
			end
		end else begin
			for (int k = LEVELS; k > 0; k--) begin
				lvl = k - 1;
				if (r.status == mlpq_pkg::ST_EMPTY && shadow_count[lvl] != 0) begin
					r.status = mlpq_pkg::ST_REMOVED;
					r.value = shadow_words[lvl][shadow_head[lvl]];
					r.prio = k[2:0];
					shadow_head[lvl] = (shadow_head[lvl] + 1) % LEVEL_DEPTH;
					shadow_count[lvl]--;
				end
			end
		end
		return r;
	endfunction

	task automatic push_cmd(logic cmd, logic [31:0] val, logic [2:0] p, int unsigned gap);
		queue_cmd_t c;
		c.drain = 1'b0;
		c.command = cmd;
		c.value = val;
		c.prio = p;
		c.gap = gap;
		cmd_backlog.push_back(c);
	endtask

	task automatic push_drain();
		queue_cmd_t c;
		c.drain = 1'b1;
		c.command = mlpq_pkg::CMD_INSERT;
		c.value = '0;
		c.prio = '0;
		c.gap = 0;
		cmd_backlog.push_back(c);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 11))
			0: rand_word = 32'h8000_0000;
			1: rand_word = 32'h7fff_ffff;
			2: rand_word = 32'hffff_ffff;
			3: rand_word = 32'h0000_0000;
			default: rand_word = $urandom;
		endcase
	endfunction

	function automatic int unsigned rand_gap();
		if ($urandom_range(0, 15) == 0)
			rand_gap = $urandom_range(6, 30);
		else if ($urandom_range(0, 2) == 0)
			rand_gap = $urandom_range(1, 3);
		else
			rand_gap = 0;
	endfunction

	// driver: new word at the falling edge once the previous one was taken
	always @(negedge clk) begin : drive_proc
		queue_cmd_t nxt;
		if (arst_n && !(start && !took)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (cmd_backlog.size() == 0) begin
				start <= 1'b0;
				all_sent <= 1'b1;
			end else if (cmd_backlog[0].drain) begin
				start <= 1'b0;
				if (expected_replies.size() == 0)
					void'(cmd_backlog.pop_front());
			end else begin
				nxt = cmd_backlog.pop_front();
				command <= nxt.command;
				value <= nxt.value;
				priority_req <= nxt.prio;
				gap_left <= nxt.gap;
				start <= 1'b1;
			end
		end
	end

	// monitor: check results, then predict for the word accepted at this edge
	always @(posedge clk) begin : watch_proc
		queue_reply_t e;
		queue_cmd_t c;
		took <= arst_n && start && !busy;
		if (arst_n && done === 1'b1) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected result: status %0d value %0d priority %0d",
					status, removed_value, removed_priority);
				err_count++;
			end else begin
				e = expected_replies.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					err_count++;
				end
				if (removed_value !== e.value) begin
					$error("removed_value: expected %0d, got %0d", e.value, $signed(removed_value));
					err_count++;
				end
				if (removed_priority !== e.prio) begin
					$error("removed_priority: expected %0d, got %0d", e.prio, removed_priority);
					err_count++;
				end
				case (e.status)
					mlpq_pkg::ST_INSERTED: n_ins++;
					mlpq_pkg::ST_REMOVED:  n_rem++;
					mlpq_pkg::ST_FULL:     n_full++;
					mlpq_pkg::ST_EMPTY:    n_empty++;
					default:               n_bad++;
				endcase
			end
		end
		if (arst_n && start === 1'b1 && busy === 1'b0) begin
			c.drain = 1'b0;
			c.command = command;
			c.value = value;
			c.prio = priority_req;
			c.gap = 0;
			expected_replies.push_back(predict_queue_op(c));
		end
	end

	initial begin : stim_proc
		int unsigned mode, focus, quiet, guard;
		logic [2:0] p;
		for (int i = 0; i < LEVELS; i++) begin
			shadow_head[i] = 0;
			shadow_count[i] = 0;
		end

		// directed: empty queue, bad priorities, one word per level, strict order out
		push_cmd(mlpq_pkg::CMD_REMOVE, 32'h1234_5678, 3'd7, 0);
		push_cmd(mlpq_pkg::CMD_INSERT, 32'h1111_1111, 3'd0, 0);
		push_cmd(mlpq_pkg::CMD_INSERT, 32'h2222_2222, 3'd6, 1);
		push_cmd(mlpq_pkg::CMD_INSERT, 32'h3333_3333, 3'd7, 0);
		push_cmd(mlpq_pkg::CMD_INSERT, 32'h8000_0000, 3'd1, 0);
		push_cmd(mlpq_pkg::CMD_INSERT, 32'h7fff_ffff, 3'd3, 0);
		push_cmd(mlpq_pkg::CMD_INSERT, 32'hffff_ffff, 3'd5, 2);
		push_cmd(mlpq_pkg::CMD_INSERT, 32'h0000_0000, 3'd2, 0);
		push_cmd(mlpq_pkg::CMD_INSERT, 32'h5555_5555, 3'd4, 0);
		for (int i = 0; i < LEVELS; i++)
			push_cmd(mlpq_pkg::CMD_REMOVE, $urandom, 3'($urandom_range(0, 7)), 0);
		push_cmd(mlpq_pkg::CMD_REMOVE, 32'hffff_ffff, 3'd0, 0);
		// fill the lowest level past its depth
		for (int i = 0; i <= LEVEL_DEPTH; i++)
			push_cmd(mlpq_pkg::CMD_INSERT, 32'haaaa_aaaa ^ i, 3'd1, 0);
		push_drain();

		// random: blocks leaning toward filling, emptying or neither
		for (int b = 0; b < 12; b++) begin
			mode = $urandom_range(0, 2);
			focus = ($urandom_range(0, 1) == 0) ? $urandom_range(1, LEVELS) : 0;
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(0, 99) < (mode == 0 ? 75 : mode == 1 ? 25 : 50)) begin
					if ($urandom_range(0, 11) == 0)
						p = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(6, 7));
					else if (focus != 0 && $urandom_range(0, 3) != 0)
						p = 3'(focus);
					else
						p = 3'($urandom_range(1, LEVELS));
					push_cmd(mlpq_pkg::CMD_INSERT, rand_word(), p, quiet ? 0 : rand_gap());
				end else begin
					push_cmd(mlpq_pkg::CMD_REMOVE, $urandom, 3'($urandom_range(0, 7)),
						quiet ? 0 : rand_gap());
				end
			end
			if (b == 5)
				push_drain();
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (all_sent);
		guard = 0;
		while (expected_replies.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		if (expected_replies.size() != 0) begin
			$display("timed out with %0d results outstanding", expected_replies.size());
			$display("TB_ERROR");
			$finish;
		end else begin
			repeat (10) @(posedge clk);
			$display("checked %0d results: %0d inserts, %0d removes, %0d level full,",
				n_ins + n_rem + n_full + n_empty + n_bad, n_ins, n_rem, n_full);
			$display("  %0d queue empty, %0d bad priority; %0d mismatches",
				n_empty, n_bad, err_count);
			if (err_count == 0)
				$display("TB_OK");
			else
				$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		#5_000_000;
		$display("run did not complete in time");
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
